@@ src/xmodem_receiver_macros.svh @@
// Assertion macros shared by the checker.
`ifndef XMODEM_RECEIVER_MACROS_SVH
`define XMODEM_RECEIVER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define XMR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("xmodem_receiver: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define XMR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("xmodem_receiver: next-cycle check failed");

`endif

@@ src/xmr_pkg.sv @@
`timescale 1ns / 1ps
package xmr_pkg;

  // Block geometry
  localparam int BLOCK_BYTES = 128;
  localparam int CNT_W       = $clog2(BLOCK_BYTES);

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int Q_AW        = $clog2(QUEUE_DEPTH);

  // Result queue at the output
  localparam int OUTQ_DEPTH  = 2;
  localparam int OQ_AW       = $clog2(OUTQ_DEPTH);

  // Line characters
  localparam logic [7:0] CH_SOH      = 8'h01;
  localparam logic [7:0] CH_EOT      = 8'h04;
  localparam logic [7:0] CH_ACK      = 8'h06;
  localparam logic [7:0] CH_NAK      = 8'h15;
  localparam logic [7:0] CH_POLL_CRC = 8'h43;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_CRC_MODE = 2'd0,
    CFG_POLL     = 2'd1,
    CFG_TIMEOUT  = 2'd2,
    CFG_UNUSED   = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic       soh;
    logic       eot;
  } op_item_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_WAIT = 3'd1,
    PH_NUM1 = 3'd2,
    PH_NUM2 = 3'd3,
    PH_DATA = 3'd4,
    PH_CHK1 = 3'd5,
    PH_CHK2 = 3'd6,
    PH_NEXT = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    KIND_TX      = 3'd0,
    KIND_DATA    = 3'd1,
    KIND_DONE    = 3'd2,
    KIND_TIMEOUT = 3'd3,
    KIND_ERROR   = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       block_end;
    logic       block_good;
  } result_t;

  typedef struct packed {
    logic        crc_mode;
    logic [15:0] poll_ticks;
    logic [19:0] timeout_ticks;
  } cfg_t;

  // CRC-16/XMODEM, one byte, polynomial 0x1021, MSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ 16'h1021;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ src/xmr_front.sv @@
`timescale 1ns / 1ps
module xmr_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [1:0]        in_cmd,
  input  logic [7:0]        in_rx_byte,
  output logic              op_valid,
  output xmr_pkg::op_item_t op_item,
  input  logic              op_take
);
  import xmr_pkg::*;

  op_item_t        q_r [QUEUE_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]   cnt_r, cnt_nxt;
  logic            accept;
  logic            keep;
  op_item_t        cls;

  assign in_full  = (cnt_r == (Q_AW + 1)'(QUEUE_DEPTH));
  assign accept   = in_push && !in_full;
  assign op_valid = (cnt_r != '0);
  assign op_item  = q_r[rd_ptr_r];

  // Classify the incoming item; drop commands that mean nothing
  always_comb begin
    keep     = 1'b1;
    cls.op   = OP_TICK;
    cls.data = in_rx_byte;
    cls.soh  = (in_rx_byte == CH_SOH);
    cls.eot  = (in_rx_byte == CH_EOT);
    case (cmd_t'(in_cmd))
      CMD_START: cls.op = OP_START;
      CMD_BYTE:  cls.op = OP_BYTE;
      CMD_TICK:  cls.op = OP_TICK;
      default:   keep   = 1'b0;
    endcase
  end

  // Advance queue pointers
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (accept && keep) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (op_take) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    case ({accept && keep, op_take})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Hold queued items
  always_ff @(posedge clk) begin
    if (accept && keep) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

@@ src/xmr_back.sv @@
`timescale 1ns / 1ps
module xmr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  xmr_pkg::cfg_t     cfg,
  input  logic              op_valid,
  input  xmr_pkg::op_item_t op_item,
  output logic              op_take,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [2:0]        out_kind,
  output logic [7:0]        out_byte,
  output logic              out_block_end,
  output logic              out_block_good
);
  import xmr_pkg::*;

  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       first_r, first_nxt;
  logic [19:0]      elapsed_r, elapsed_nxt;
  logic [15:0]      poll_r, poll_nxt;

  result_t          oq_r [OUTQ_DEPTH];
  logic [OQ_AW-1:0] owr_r, owr_nxt;
  logic [OQ_AW-1:0] ord_r, ord_nxt;
  logic [OQ_AW:0]   ocnt_r, ocnt_nxt;
  logic             emit;
  result_t          res;
  result_t          head;

  logic [19:0]      elapsed_inc;
  logic [15:0]      poll_inc;
  logic             timed_out;
  logic             poll_hit;
  logic             last_byte;
  logic             sum_good;
  logic             crc_good;
  logic [7:0]       poll_char;
  logic             is_start, is_byte, is_tick;
  logic             out_take;

  assign op_take   = op_valid && (ocnt_r != (OQ_AW + 1)'(OUTQ_DEPTH));
  assign is_start  = op_take && (op_item.op == OP_START);
  assign is_byte   = op_take && (op_item.op == OP_BYTE);
  assign is_tick   = op_take && (op_item.op == OP_TICK) && (phase_r == PH_WAIT);

  // Shared datapath terms
  assign elapsed_inc = elapsed_r + 20'd1;
  assign poll_inc    = poll_r + 16'd1;
  assign timed_out   = (elapsed_inc >= cfg.timeout_ticks);
  assign poll_hit    = (poll_inc >= cfg.poll_ticks);
  assign last_byte   = (count_r == CNT_W'(BLOCK_BYTES - 1));
  assign sum_good    = (op_item.data == sum_r);
  assign crc_good    = ({first_r, op_item.data} == crc_r);
  assign poll_char   = cfg.crc_mode ? CH_POLL_CRC : CH_NAK;

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (is_start) begin
      phase_nxt = PH_WAIT;
    end else if (is_tick) begin
      if (timed_out) begin
        phase_nxt = PH_IDLE;
      end
    end else if (is_byte) begin
      case (phase_r)
        PH_WAIT: if (op_item.soh) phase_nxt = PH_NUM1;
        PH_NUM1: phase_nxt = PH_NUM2;
        PH_NUM2: phase_nxt = PH_DATA;
        PH_DATA: if (last_byte) phase_nxt = PH_CHK1;
        PH_CHK1: phase_nxt = cfg.crc_mode ? PH_CHK2 : PH_NEXT;
        PH_CHK2: phase_nxt = PH_NEXT;
        PH_NEXT: phase_nxt = op_item.soh ? PH_NUM1 : PH_IDLE;
        default: phase_nxt = phase_r;
      endcase
    end
  end

  // Counters, running checks and timers
  always_comb begin
    count_nxt   = count_r;
    sum_nxt     = sum_r;
    crc_nxt     = crc_r;
    first_nxt   = first_r;
    elapsed_nxt = elapsed_r;
    poll_nxt    = poll_r;
    if (is_start) begin
      count_nxt   = '0;
      sum_nxt     = '0;
      crc_nxt     = '0;
      first_nxt   = '0;
      elapsed_nxt = '0;
      poll_nxt    = '0;
    end else if (is_tick) begin
      elapsed_nxt = elapsed_inc;
      if (!timed_out) begin
        poll_nxt = poll_hit ? 16'd0 : poll_inc;
      end
    end else if (is_byte) begin
      case (phase_r)
        PH_NUM2: begin
          count_nxt = '0;
          sum_nxt   = '0;
          crc_nxt   = '0;
        end
        PH_DATA: begin
          count_nxt = count_r + 1'b1;
          sum_nxt   = sum_r + op_item.data;
          crc_nxt   = crc16_byte(crc_r, op_item.data);
        end
        PH_CHK1: if (cfg.crc_mode) first_nxt = op_item.data;
        default: count_nxt = count_r;
      endcase
    end
  end

  // Result for this item
  always_comb begin
    emit           = 1'b0;
    res.kind       = KIND_TX;
    res.data       = 8'h00;
    res.block_end  = 1'b0;
    res.block_good = 1'b0;
    if (is_start) begin
      emit     = 1'b1;
      res.data = poll_char;
    end else if (is_tick) begin
      if (timed_out) begin
        emit     = 1'b1;
        res.kind = KIND_TIMEOUT;
      end else if (poll_hit) begin
        emit     = 1'b1;
        res.data = poll_char;
      end
    end else if (is_byte) begin
      case (phase_r)
        PH_DATA: begin
          emit     = 1'b1;
          res.kind = KIND_DATA;
          res.data = op_item.data;
        end
        PH_CHK1: begin
          if (!cfg.crc_mode) begin
            emit           = 1'b1;
            res.data       = sum_good ? CH_ACK : CH_NAK;
            res.block_end  = 1'b1;
            res.block_good = sum_good;
          end
        end
        PH_CHK2: begin
          emit           = 1'b1;
          res.data       = crc_good ? CH_ACK : CH_NAK;
          res.block_end  = 1'b1;
          res.block_good = crc_good;
        end
        PH_NEXT: begin
          if (!op_item.soh) begin
            emit = 1'b1;
            if (op_item.eot) begin
              res.kind = KIND_DONE;
              res.data = CH_ACK;
            end else begin
              res.kind = KIND_ERROR;
            end
          end
        end
        default: emit = 1'b0;
      endcase
    end
  end

  // Result queue pointers
  assign out_take = out_pop && !out_empty;
  always_comb begin
    owr_nxt  = emit ? owr_r + 1'b1 : owr_r;
    ord_nxt  = out_take ? ord_r + 1'b1 : ord_r;
    case ({emit, out_take})
      2'b10:   ocnt_nxt = ocnt_r + 1'b1;
      2'b01:   ocnt_nxt = ocnt_r - 1'b1;
      default: ocnt_nxt = ocnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      count_r   <= '0;
      sum_r     <= '0;
      crc_r     <= '0;
      first_r   <= '0;
      elapsed_r <= '0;
      poll_r    <= '0;
      owr_r     <= '0;
      ord_r     <= '0;
      ocnt_r    <= '0;
    end else begin
      phase_r   <= phase_nxt;
      count_r   <= count_nxt;
      sum_r     <= sum_nxt;
      crc_r     <= crc_nxt;
      first_r   <= first_nxt;
      elapsed_r <= elapsed_nxt;
      poll_r    <= poll_nxt;
      owr_r     <= owr_nxt;
      ord_r     <= ord_nxt;
      ocnt_r    <= ocnt_nxt;
    end
  end

  // Hold results until popped
  always_ff @(posedge clk) begin
    if (emit) begin
      oq_r[owr_r] <= res;
    end
  end

  assign head           = oq_r[ord_r];
  assign out_empty      = (ocnt_r == '0);
  assign out_kind       = head.kind;
  assign out_byte       = head.data;
  assign out_block_end  = head.block_end;
  assign out_block_good = head.block_good;

endmodule

@@ src/xmodem_receiver.sv @@
`timescale 1ns / 1ps
// Channel   Handshake          Payload
// input     in_push / in_full  in_cmd[1:0], in_rx_byte[7:0]
// result    out_pop / out_empty out_kind[2:0], out_byte[7:0], out_block_end, out_block_good
// config    cfg_valid / cfg_ready cfg_index[1:0], cfg_data[19:0]
//
// One item per cycle sustained while the result queue has room; an accepted item goes
// through the front queue; the protocol engine then puts its result in the result queue.
// The per-byte CRC update is one unrolled byte step in the protocol engine.
// rst_n is synchronous; both queues come out empty, the engine idle, config at defaults.
// in_full rises only when the four-entry front queue fills, i.e. when results stall.
// cfg_ready is always high.
module xmodem_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_rx_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic        out_block_end,
  output logic        out_block_good,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);
  import xmr_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  logic     op_valid;
  op_item_t op_item;
  logic     op_take;

  assign cfg_ready = 1'b1;

  // Decode register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CRC_MODE: cfg_nxt.crc_mode      = cfg_data[0];
        CFG_POLL:     cfg_nxt.poll_ticks    = cfg_data[15:0];
        CFG_TIMEOUT:  cfg_nxt.timeout_ticks = cfg_data;
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.crc_mode      <= 1'b0;
      cfg_r.poll_ticks    <= 16'd5;
      cfg_r.timeout_ticks <= 20'd60000;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  xmr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_cmd     (in_cmd),
    .in_rx_byte (in_rx_byte),
    .op_valid   (op_valid),
    .op_item    (op_item),
    .op_take    (op_take)
  );

  xmr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .op_valid       (op_valid),
    .op_item        (op_item),
    .op_take        (op_take),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_kind       (out_kind),
    .out_byte       (out_byte),
    .out_block_end  (out_block_end),
    .out_block_good (out_block_good)
  );

endmodule

@@ src/xmr_checker.sv @@
`timescale 1ns / 1ps
`include "xmodem_receiver_macros.svh"
module xmr_props (
  input logic       clk,
  input logic       rst_n,
  input logic       in_full,
  input logic       out_empty,
  input logic       out_pop,
  input logic [2:0] out_kind,
  input logic [7:0] out_byte,
  input logic       out_block_end,
  input logic       out_block_good
);
  import xmr_pkg::*;

  // A good verdict is always a block verdict
  `XMR_ASSERT_IMP(a_good_is_end, !out_empty && out_block_good, out_block_end)

  // A block verdict is a transmitted ACK or NAK
  `XMR_ASSERT_IMP(a_end_is_verdict, !out_empty && out_block_end, out_kind == KIND_TX && (out_byte == CH_ACK || out_byte == CH_NAK))

  // A result that is not popped stays on the ports
  `XMR_ASSERT_NXT(a_hold_result, !out_empty && !out_pop, !out_empty && $stable(out_kind) && $stable(out_byte))

  // Nothing can be pending right after reset
  `XMR_ASSERT_IMP(a_reset_empty, $past(!rst_n), out_empty && !in_full)

endmodule

bind xmodem_receiver xmr_props u_chk (.*);

@@ tb/xmr_checker.sv @@
`timescale 1ns / 1ps
package xmr_line_pkg;

  // CRC-16/XMODEM over one byte, shifted in one bit at a time, MSB first
  function automatic logic [15:0] crc_xmodem_step(input logic [15:0] crc,
                                                  input logic [7:0]  b);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r  = {r[14:0], 1'b0};
      if (fb) begin
        r = r ^ 16'h1021;
      end
    end
    return r;
  endfunction

endpackage

module xmr_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic        in_full,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic [2:0]  out_kind,
  input  logic [7:0]  out_byte,
  input  logic        out_block_end,
  input  logic        out_block_good,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data,
  output int          fail_count,
  output int          waiting
);
  import xmr_pkg::*;
  import xmr_line_pkg::*;

  // Results the receiver owes, oldest first
  result_t owed_results[$];
  result_t head;

  // Shadow of the configuration registers
  logic        mode_crc;
  logic [15:0] poll_limit;
  logic [19:0] timeout_limit;

  // Shadow of the protocol state
  phase_t      rx_phase;
  logic [10:0] data_count;
  logic [7:0]  sum_acc;
  logic [15:0] crc_acc;
  logic [7:0]  crc_hi;
  logic [19:0] tick_count;
  logic [15:0] poll_count;

  function automatic result_t make_result(input kind_t k, input logic [7:0] d,
                                          input logic e, input logic g);
    result_t r;
    r.kind       = k;
    r.data       = d;
    r.block_end  = e;
    r.block_good = g;
    return r;
  endfunction

  // Append one result behind the ones already owed
  function automatic void owe_result(input result_t r);
    owed_results.insert(owed_results.size(), r);
  endfunction

  // Advance the protocol by one item and queue the result it causes, if any
  task automatic advance_protocol(input cmd_t c, input logic [7:0] b);
    logic       good;
    logic [7:0] poll_char;
    poll_char = mode_crc ? CH_POLL_CRC : CH_NAK;
    case (c)
      CMD_START: begin
        rx_phase   = PH_WAIT;
        tick_count = '0;
        poll_count = '0;
        data_count = '0;
        sum_acc    = '0;
        crc_acc    = '0;
        crc_hi     = '0;
        owe_result(make_result(KIND_TX, poll_char, 1'b0, 1'b0));
      end
      CMD_TICK: begin
        if (rx_phase == PH_WAIT) begin
          tick_count = tick_count + 20'd1;
          if (tick_count >= timeout_limit) begin
            rx_phase = PH_IDLE;
            owe_result(make_result(KIND_TIMEOUT, 8'h00, 1'b0, 1'b0));
          end else begin
            poll_count = poll_count + 16'd1;
            if (poll_count >= poll_limit) begin
              poll_count = '0;
              owe_result(make_result(KIND_TX, poll_char, 1'b0, 1'b0));
            end
          end
        end
      end
      CMD_BYTE: begin
        case (rx_phase)
          PH_WAIT: begin
            if (b == CH_SOH) begin
              rx_phase = PH_NUM1;
            end
          end
          PH_NUM1: rx_phase = PH_NUM2;
          PH_NUM2: begin
            rx_phase   = PH_DATA;
            data_count = '0;
            sum_acc    = '0;
            crc_acc    = '0;
          end
          PH_DATA: begin
            sum_acc    = sum_acc + b;
            crc_acc    = crc_xmodem_step(crc_acc, b);
            data_count = data_count + 11'd1;
            if (data_count >= BLOCK_BYTES) begin
              rx_phase = PH_CHK1;
            end
            owe_result(make_result(KIND_DATA, b, 1'b0, 1'b0));
          end
          PH_CHK1: begin
            if (mode_crc) begin
              crc_hi   = b;
              rx_phase = PH_CHK2;
            end else begin
              good     = (b == sum_acc);
              rx_phase = PH_NEXT;
              owe_result(make_result(KIND_TX, good ? CH_ACK : CH_NAK, 1'b1, good));
            end
          end
          PH_CHK2: begin
            good     = ({crc_hi, b} == crc_acc);
            rx_phase = PH_NEXT;
            owe_result(make_result(KIND_TX, good ? CH_ACK : CH_NAK, 1'b1, good));
          end
          PH_NEXT: begin
            if (b == CH_SOH) begin
              rx_phase = PH_NUM1;
            end else begin
              rx_phase = PH_IDLE;
              if (b == CH_EOT) begin
                owe_result(make_result(KIND_DONE, CH_ACK, 1'b0, 1'b0));
              end else begin
                owe_result(make_result(KIND_ERROR, 8'h00, 1'b0, 1'b0));
              end
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      owed_results.delete();
      fail_count    = 0;
      mode_crc      = 1'b0;
      poll_limit    = 16'd5;
      timeout_limit = 20'd60000;
      rx_phase      = PH_IDLE;
      data_count    = '0;
      sum_acc       = '0;
      crc_acc       = '0;
      crc_hi        = '0;
      tick_count    = '0;
      poll_count    = '0;
    end else begin
      // Compare each popped item against the oldest owed result
      if (out_pop && !out_empty) begin
        if (owed_results.size() == 0) begin
          $error("unexpected result: kind %0d byte %02h", out_kind, out_byte);
          fail_count++;
        end else begin
          head = owed_results.pop_front();
          if (out_kind !== head.kind) begin
            $error("kind: expected %0d, got %0d", head.kind, out_kind);
            fail_count++;
          end
          if (out_byte !== head.data) begin
            $error("out_byte: expected %02h, got %02h", head.data, out_byte);
            fail_count++;
          end
          if (out_block_end !== head.block_end) begin
            $error("block_end: expected %0d, got %0d", head.block_end, out_block_end);
            fail_count++;
          end
          if (out_block_good !== head.block_good) begin
            $error("block_good: expected %0d, got %0d", head.block_good, out_block_good);
            fail_count++;
          end
        end
      end

      // Track register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_CRC_MODE: mode_crc      = cfg_data[0];
          CFG_POLL:     poll_limit    = cfg_data[15:0];
          CFG_TIMEOUT:  timeout_limit = cfg_data;
          default: ;
        endcase
      end

      // Predict from each accepted item
      if (in_push && !in_full) begin
        advance_protocol(cmd_t'(in_cmd), in_rx_byte);
      end
    end
    waiting = owed_results.size();
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import xmr_pkg::*;
  import xmr_line_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 8;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [1:0]  in_cmd;
  logic [7:0]  in_rx_byte;
  logic        out_empty;
  logic        out_pop;
  logic [2:0]  out_kind;
  logic [7:0]  out_byte;
  logic        out_block_end;
  logic        out_block_good;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [19:0] cfg_data;

  int fail_count;
  int waiting;
  int cycle_count;
  int items_sent;
  int send_idle_pct;
  int recv_idle_pct;

  bit stall_req;
  bit hold_taken;
  int hold_left;

  // What the stimulus knows of the current setting
  logic        cur_crc_mode;
  logic [19:0] cur_timeout;

  xmodem_receiver dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_cmd         (in_cmd),
    .in_rx_byte     (in_rx_byte),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_kind       (out_kind),
    .out_byte       (out_byte),
    .out_block_end  (out_block_end),
    .out_block_good (out_block_good),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  xmr_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_cmd         (in_cmd),
    .in_rx_byte     (in_rx_byte),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_kind       (out_kind),
    .out_byte       (out_byte),
    .out_block_end  (out_block_end),
    .out_block_good (out_block_good),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .waiting        (waiting)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Give up if the run hangs
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Result side: random pops, plus one long hold-off when asked
  initial begin
    out_pop    = 1'b0;
    hold_taken = 1'b0;
    hold_left  = 0;
    forever begin
      @(negedge clk);
      if (stall_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one item, with random gaps ahead of it, and hold until accepted
  task automatic push_item(input cmd_t c, input logic [7:0] b, input bit counted);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push    <= 1'b1;
    in_cmd     <= c;
    in_rx_byte <= b;
    do @(posedge clk); while (in_full);
    if (counted) begin
      items_sent++;
    end
  endtask

  // Stop offering and wait until every owed result has been popped
  task automatic drain();
    @(negedge clk);
    in_push <= 1'b0;
    do @(negedge clk); while (waiting != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [19:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input logic crc, input logic [15:0] poll,
                           input logic [19:0] tmo);
    drain();
    write_reg(CFG_CRC_MODE, {19'd0, crc});
    write_reg(CFG_POLL, {4'd0, poll});
    write_reg(CFG_TIMEOUT, tmo);
    cur_crc_mode = crc;
    cur_timeout  = tmo;
  endtask

  // Send SOH, block number pair, data and check; cut short at stop_at if >= 0
  task automatic send_block(input bit corrupt, input int stop_at);
    logic [7:0]  num;
    logic [7:0]  sum;
    logic [7:0]  d;
    logic [15:0] crc;
    push_item(CMD_BYTE, CH_SOH, 1'b1);
    num = 8'($urandom_range(255));
    push_item(CMD_BYTE, num, 1'b1);
    push_item(CMD_BYTE, ~num, 1'b1);
    sum = '0;
    crc = '0;
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      if (i == stop_at) begin
        return;
      end
      d   = 8'($urandom_range(255));
      sum = sum + d;
      crc = crc_xmodem_step(crc, d);
      push_item(CMD_BYTE, d, 1'b1);
    end
    if (corrupt) begin
      sum = sum ^ 8'($urandom_range(1, 255));
      crc = crc ^ 16'($urandom_range(1, 65535));
    end
    if (cur_crc_mode) begin
      push_item(CMD_BYTE, crc[15:8], 1'b1);
      push_item(CMD_BYTE, crc[7:0], 1'b1);
    end else begin
      push_item(CMD_BYTE, sum, 1'b1);
    end
  endtask

  // One reception: start, polling ticks, a few blocks, then usually a closing byte; some end early
  task automatic run_session();
    int         n_ticks;
    int         n_blocks;
    int         r;
    logic [7:0] b;
    push_item(CMD_START, 8'($urandom_range(255)), 1'b1);
    // Let the wait run out now and then
    if ($urandom_range(9) == 0 && cur_timeout <= 200) begin
      repeat (cur_timeout) push_item(CMD_TICK, 8'($urandom_range(255)), 1'b1);
      return;
    end
    n_ticks = $urandom_range(0, (cur_timeout > 12) ? 12 : cur_timeout - 1);
    repeat (n_ticks) begin
      if ($urandom_range(3) == 0) begin
        b = 8'($urandom_range(255));
        if (b == CH_SOH) begin
          b = 8'h00;
        end
        push_item(CMD_BYTE, b, 1'b1);
      end
      push_item(CMD_TICK, 8'($urandom_range(255)), 1'b1);
    end
    n_blocks = $urandom_range(1, 3);
    repeat (n_blocks) begin
      if ($urandom_range(19) == 0) begin
        send_block(1'b0, $urandom_range(0, BLOCK_BYTES - 1));
        return;
      end
      send_block($urandom_range(4) == 0, -1);
    end
    r = $urandom_range(9);
    if (r < 7) begin
      push_item(CMD_BYTE, CH_EOT, 1'b1);
    end else if (r < 9) begin
      b = 8'($urandom_range(255));
      if (b == CH_SOH || b == CH_EOT) begin
        b = 8'hFF;
      end
      push_item(CMD_BYTE, b, 1'b1);
    end
  endtask

  // Random sessions with a little noise between them, up to a running item count
  task automatic run_random(input int goal);
    while (items_sent < goal) begin
      if ($urandom_range(9) == 0) begin
        push_item(cmd_t'($urandom_range(3)), 8'($urandom_range(255)), 1'b0);
      end
      run_session();
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_push       = 1'b0;
    in_cmd        = CMD_NONE;
    in_rx_byte    = 8'h00;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_CRC_MODE;
    cfg_data      = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_req     = 1'b0;
    items_sent    = 0;
    cur_crc_mode  = 1'b0;
    cur_timeout   = 20'd60000;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: idle noise, polling every tick, stray bytes, timeout, restart
    configure(1'b0, 16'd0, 20'd3);
    push_item(CMD_BYTE, 8'hFF, 1'b0);
    push_item(CMD_TICK, 8'h00, 1'b0);
    push_item(CMD_NONE, 8'hAA, 1'b0);
    push_item(CMD_START, 8'h00, 1'b0);
    push_item(CMD_TICK, 8'h55, 1'b0);
    push_item(CMD_BYTE, 8'h00, 1'b0);
    push_item(CMD_BYTE, CH_EOT, 1'b0);
    push_item(CMD_TICK, 8'h00, 1'b0);
    push_item(CMD_TICK, 8'h00, 1'b0);
    push_item(CMD_START, 8'hFF, 1'b0);
    push_item(CMD_BYTE, CH_SOH, 1'b0);
    push_item(CMD_BYTE, 8'hFF, 1'b0);
    push_item(CMD_START, 8'h00, 1'b0);
    push_item(CMD_TICK, 8'h00, 1'b0);
    // Zero timeout ends the wait at the first tick
    configure(1'b1, 16'hFFFF, 20'd0);
    push_item(CMD_START, 8'h00, 1'b0);
    push_item(CMD_TICK, 8'h00, 1'b0);
    push_item(CMD_TICK, 8'h00, 1'b0);
    drain();
    write_reg(CFG_UNUSED, 20'hFFFFF);

    // Random: sender idles lightly, receiver heavily
    send_idle_pct = 8;
    recv_idle_pct = 64;
    configure(1'b0, 16'd3, 20'd40);
    run_random(700);

    // Random: the other way round, widest poll and timeout
    send_idle_pct = 64;
    recv_idle_pct = 8;
    configure(1'b1, 16'hFFFF, 20'hFFFFF);
    run_random(1400);

    // Random: no idling, one long hold-off on the result side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(1'b0, 16'd1, 20'd25);
    stall_req = 1'b1;
    run_random(1750);
    configure(1'b1, 16'd2, 20'd30);
    run_random(2100);

    drain();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
